// ----- hw/rtl/euclidean_distance_transform_defines.svh -----
// Assertion macros for the distance transform block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef EUCLIDEAN_DISTANCE_TRANSFORM_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_TRANSFORM_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edt assertion failed");

// next-cycle implication, disabled in reset
`define EDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edt assertion failed");

`endif

// ----- hw/rtl/edt_pkg.sv -----
// Shared types, constants and neighbor tables for the distance transform.
// No dependencies.
package edt_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam logic signed [15:0] FAR_OFFSET = 16'sd32000;
    localparam logic [7:0]         CFG_RESET  = 8'd128;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] SCAN_FWD_ROW   = 2'd0;
    localparam logic [1:0] SCAN_FWD_RIGHT = 2'd1;
    localparam logic [1:0] SCAN_BWD_ROW   = 2'd2;
    localparam logic [1:0] SCAN_BWD_LEFT  = 2'd3;

    localparam logic signed [1:0] STEP_NEG  = -2'sd1;
    localparam logic signed [1:0] STEP_ZERO = 2'sd0;
    localparam logic signed [1:0] STEP_POS  = 2'sd1;

    typedef struct packed {
        logic signed [1:0] dc;
        logic signed [1:0] dr;
    } t_step;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    function automatic t_step nb_step(input logic [1:0] scan, input logic [1:0] k);
        t_step s;
        s.dc = STEP_ZERO;
        s.dr = STEP_ZERO;
        case (scan)
            SCAN_FWD_ROW: begin
                case (k)
                    2'd0:    begin s.dc = STEP_NEG;  s.dr = STEP_ZERO; end
                    2'd1:    begin s.dc = STEP_NEG;  s.dr = STEP_NEG;  end
                    2'd2:    begin s.dc = STEP_ZERO; s.dr = STEP_NEG;  end
                    default: begin s.dc = STEP_POS;  s.dr = STEP_NEG;  end
                endcase
            end
            SCAN_FWD_RIGHT: begin
                s.dc = STEP_POS;
            end
            SCAN_BWD_ROW: begin
                case (k)
                    2'd0:    begin s.dc = STEP_POS;  s.dr = STEP_ZERO; end
                    2'd1:    begin s.dc = STEP_POS;  s.dr = STEP_POS;  end
                    2'd2:    begin s.dc = STEP_ZERO; s.dr = STEP_POS;  end
                    default: begin s.dc = STEP_NEG;  s.dr = STEP_POS;  end
                endcase
            end
            default: begin
                s.dc = STEP_NEG;
            end
        endcase
        return s;
    endfunction

    function automatic logic [2:0] nb_count(input logic [1:0] scan);
        logic [2:0] c;
        case (scan)
            SCAN_FWD_ROW: c = 3'd4;
            SCAN_BWD_ROW: c = 3'd4;
            default:      c = 3'd1;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/edt_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module edt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- hw/rtl/edt_sweep.sv -----
// Sweep sequencer: read-modify-write of offsets in the shared memory.
// Depends on edt_pkg.
module edt_sweep #(
    parameter int MAX_WIDTH  = edt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = edt_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]              i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]             i_height,
    output logic                                        o_done,
    output edt_pkg::t_mem_ctl                           o_mem,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     o_rd_addr,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     o_wr_addr,
    output logic [31:0]                                 o_wr_data,
    input  logic [31:0]                                 i_rd_data
);
    import edt_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CUR  = 4'd1;
    localparam logic [3:0] S_CURD = 4'd2;
    localparam logic [3:0] S_NRD  = 4'd3;
    localparam logic [3:0] S_NDAT = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_ADV  = 4'd8;

    logic [3:0]         r_state;
    logic [1:0]         r_scan;
    logic [2:0]         r_k;
    logic [XW-1:0]      r_x;
    logic [YW-1:0]      r_y;
    logic [AW-1:0]      r_base;
    logic               r_changed;
    logic               r_upd;
    logic               r_is_cur;
    logic               r_done;
    logic signed [15:0] r_cx;
    logic signed [15:0] r_cy;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic [32:0]        r_cur_len;

    t_step              w_step;
    logic [2:0]         w_count;
    logic               w_skip;
    logic               w_x_last;
    logic               w_fin;
    logic [AW+1:0]      w_row;
    logic [AW+1:0]      w_nsum;
    logic [AW-1:0]      w_cur_addr;
    logic [AW-1:0]      w_nb_addr;
    logic [32:0]        w_len;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [15:0] w_sx;
    logic signed [15:0] w_sy;

    assign w_step   = nb_step(r_scan, r_k[1:0]);
    assign w_count  = nb_count(r_scan);
    assign w_x_last = (r_x == i_width - XW'(1));
    assign w_skip   = ((w_step.dc == STEP_NEG) && (r_x == '0)) ||
                      ((w_step.dc == STEP_POS) && w_x_last);
    assign w_fin    = (r_scan == SCAN_BWD_LEFT) && w_x_last && (r_y == '0) && !r_changed;

    always_comb begin
        case (w_step.dr)
            STEP_NEG: w_row = (AW+2)'(r_base) - (AW+2)'(i_width);
            STEP_POS: w_row = (AW+2)'(r_base) + (AW+2)'(i_width);
            default:  w_row = (AW+2)'(r_base);
        endcase
        case (w_step.dc)
            STEP_NEG: w_nsum = w_row + (AW+2)'(r_x) - (AW+2)'(1);
            STEP_POS: w_nsum = w_row + (AW+2)'(r_x) + (AW+2)'(1);
            default:  w_nsum = w_row + (AW+2)'(r_x);
        endcase
    end

    assign w_cur_addr = AW'((AW+2)'(r_base) + (AW+2)'(r_x));
    assign w_nb_addr  = w_nsum[AW-1:0];
    assign w_len      = {1'b0, r_sqx} + {1'b0, r_sqy};

    assign w_dx = $signed({i_rd_data[15], i_rd_data[15:0]})
                - $signed({{15{w_step.dc[1]}}, w_step.dc});
    assign w_dy = $signed({i_rd_data[31], i_rd_data[31:16]})
                - $signed({{15{w_step.dr[1]}}, w_step.dr});
    assign w_sx = (w_dx[16] != w_dx[15]) ? (w_dx[16] ? 16'sh8000 : 16'sh7FFF) : w_dx[15:0];
    assign w_sy = (w_dy[16] != w_dy[15]) ? (w_dy[16] ? 16'sh8000 : 16'sh7FFF) : w_dy[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_changed <= 1'b0;
            r_upd     <= 1'b0;
            r_is_cur  <= 1'b0;
            r_scan    <= SCAN_FWD_ROW;
            r_k       <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_base    <= '0;
        end else begin
            r_done <= ((r_state == S_IDLE) && i_start && (i_height == YW'(1))) ||
                      ((r_state == S_ADV) && w_fin);
            case (r_state)
                S_IDLE: begin
                    if (i_start && (i_height != YW'(1))) begin
                        r_scan    <= SCAN_FWD_ROW;
                        r_x       <= '0;
                        r_y       <= YW'(1);
                        r_base    <= AW'(i_width);
                        r_changed <= 1'b0;
                        r_state   <= S_CUR;
                    end
                end
                S_CUR: begin
                    r_state <= S_CURD;
                end
                S_CURD: begin
                    r_px     <= i_rd_data[15:0];
                    r_py     <= i_rd_data[31:16];
                    r_is_cur <= 1'b1;
                    r_state  <= S_SQ;
                end
                S_NRD: begin
                    if (r_k == w_count) begin
                        r_state <= S_WR;
                    end else if (w_skip) begin
                        r_k <= r_k + 3'd1;
                    end else begin
                        r_state <= S_NDAT;
                    end
                end
                S_NDAT: begin
                    r_px     <= w_sx;
                    r_py     <= w_sy;
                    r_is_cur <= 1'b0;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    r_sqx   <= 32'(r_px) * 32'(r_px);
                    r_sqy   <= 32'(r_py) * 32'(r_py);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_is_cur) begin
                        r_cur_len <= w_len;
                        r_cx      <= r_px;
                        r_cy      <= r_py;
                        r_upd     <= 1'b0;
                        r_k       <= '0;
                        r_state   <= (w_len == '0) ? S_ADV : S_NRD;
                    end else begin
                        if (w_len < r_cur_len) begin
                            r_cur_len <= w_len;
                            r_cx      <= r_px;
                            r_cy      <= r_py;
                            r_upd     <= 1'b1;
                        end
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NRD;
                    end
                end
                S_WR: begin
                    if (r_upd) begin
                        r_changed <= 1'b1;
                    end
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    r_state <= w_fin ? S_IDLE : S_CUR;
                    case (r_scan)
                        SCAN_FWD_ROW: begin
                            if (w_x_last) begin
                                r_scan <= SCAN_FWD_RIGHT;
                                r_x    <= i_width - XW'(2);
                            end else begin
                                r_x <= r_x + XW'(1);
                            end
                        end
                        SCAN_FWD_RIGHT: begin
                            if (r_x == '0) begin
                                if (r_y == i_height - YW'(1)) begin
                                    r_scan <= SCAN_BWD_ROW;
                                    r_y    <= i_height - YW'(2);
                                    r_base <= r_base - AW'(i_width);
                                    r_x    <= i_width - XW'(1);
                                end else begin
                                    r_scan <= SCAN_FWD_ROW;
                                    r_y    <= r_y + YW'(1);
                                    r_base <= r_base + AW'(i_width);
                                end
                            end else begin
                                r_x <= r_x - XW'(1);
                            end
                        end
                        SCAN_BWD_ROW: begin
                            if (r_x == '0) begin
                                r_scan <= SCAN_BWD_LEFT;
                                r_x    <= XW'(1);
                            end else begin
                                r_x <= r_x - XW'(1);
                            end
                        end
                        default: begin
                            if (w_x_last) begin
                                if (r_y == '0) begin
                                    if (r_changed) begin
                                        r_changed <= 1'b0;
                                        r_scan    <= SCAN_FWD_ROW;
                                        r_x       <= '0;
                                        r_y       <= YW'(1);
                                        r_base    <= AW'(i_width);
                                    end
                                end else begin
                                    r_scan <= SCAN_BWD_ROW;
                                    r_y    <= r_y - YW'(1);
                                    r_base <= r_base - AW'(i_width);
                                    r_x    <= i_width - XW'(1);
                                end
                            end else begin
                                r_x <= r_x + XW'(1);
                            end
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_mem.rd_en = (r_state == S_CUR) ||
                         ((r_state == S_NRD) && (r_k != w_count) && !w_skip);
    assign o_mem.wr_en = (r_state == S_WR) && r_upd;
    assign o_rd_addr   = (r_state == S_CUR) ? w_cur_addr : w_nb_addr;
    assign o_wr_addr   = w_cur_addr;
    assign o_wr_data   = {r_cy, r_cx};
endmodule

// ----- hw/rtl/euclidean_distance_transform.sv -----
// Load: one pixel per cycle. Sweeps: a pixel at zero is settled once read, others
// read each neighbor inside the image; passes repeat until one changes nothing,
// and input is stalled meanwhile. Drain: one item per cycle while the output queue
// has room, via the RAM read register and the queue. Reset clears control state
// only; the offset memory is not cleared. Depends on edt_pkg, edt_ram, edt_sweep.
`include "euclidean_distance_transform_defines.svh"
module euclidean_distance_transform #(
    parameter int MAX_WIDTH  = edt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = edt_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pixel_value
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // offset_x, offset_y
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import edt_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_SWEEP = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    logic [1:0]    r_phase;
    logic [7:0]    r_cfg_w;
    logic [7:0]    r_cfg_h;
    logic [CW-1:0] r_load_cnt;
    logic [CW-1:0] r_drain_cnt;
    logic          r_start;
    logic          r_pend;
    logic          r_pend_last;
    logic [32:0]   r_q0;
    logic [32:0]   r_q1;
    logic [1:0]    r_cnt;

    logic [XW-1:0] w_eff_w;
    logic [YW-1:0] w_eff_h;
    logic [CW-1:0] w_total;
    logic          w_in_acc;
    logic          w_load;
    logic          w_drain;
    logic          w_pop;
    logic          w_space;
    logic          w_load_last;
    logic          w_drain_last;
    logic [32:0]   w_push;

    t_mem_ctl      w_swp_mem;
    logic          w_swp_done;
    logic [AW-1:0] w_swp_rd_addr;
    logic [AW-1:0] w_swp_wr_addr;
    logic [31:0]   w_swp_wr_data;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_wa;
    logic [31:0]   w_ram_wd;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_ra;
    logic [31:0]   w_ram_rd;
    logic [15:0]   w_load_val;

    always_comb begin
        if (r_cfg_w < 8'd2) begin
            w_eff_w = XW'(2);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff_w = XW'(MAX_WIDTH);
        end else begin
            w_eff_w = XW'(r_cfg_w);
        end
        if (r_cfg_h < 8'd1) begin
            w_eff_h = YW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            w_eff_h = YW'(MAX_HEIGHT);
        end else begin
            w_eff_h = YW'(r_cfg_h);
        end
    end

    assign w_total      = CW'(w_eff_w) * CW'(w_eff_h);
    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_load       = w_in_acc && (r_phase == PH_LOAD) && !s_axis_tuser;
    assign w_drain      = w_in_acc && (r_phase == PH_DRAIN) && s_axis_tuser;
    assign w_load_last  = ((CW+1)'(r_load_cnt) + (CW+1)'(1)) >= (CW+1)'(w_total);
    assign w_drain_last = ((CW+1)'(r_drain_cnt) + (CW+1)'(1)) >= (CW+1)'(w_total);
    assign w_pop        = m_axis_tvalid && m_axis_tready;
    assign w_space      = ({1'b0, r_cnt} + {2'b0, r_pend}) <= ({2'b0, w_pop} + 3'd1);
    assign w_push       = {r_pend_last, w_ram_rd};
    assign w_load_val   = ($signed(s_axis_tdata) > 16'sd0) ? 16'd0 : FAR_OFFSET;

    assign s_axis_tready = (r_phase == PH_LOAD) || ((r_phase == PH_DRAIN) && w_space);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q0[31:0];
    assign m_axis_tlast  = r_q0[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LOAD;
            r_cfg_w     <= CFG_RESET;
            r_cfg_h     <= CFG_RESET;
            r_load_cnt  <= '0;
            r_drain_cnt <= '0;
            r_start     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            r_start <= w_load && w_load_last;
            r_pend  <= w_drain;
            if (i_cfg_valid && o_cfg_ready && (r_phase == PH_LOAD) && (r_load_cnt == '0)) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:    r_cfg_w <= r_cfg_w;
                endcase
            end
            if (w_load) begin
                r_load_cnt <= r_load_cnt + CW'(1);
                if (w_load_last) begin
                    r_phase <= PH_SWEEP;
                end
            end
            if (w_swp_done) begin
                r_phase     <= PH_DRAIN;
                r_drain_cnt <= '0;
            end
            if (w_drain) begin
                r_pend_last <= w_drain_last;
                if (w_drain_last) begin
                    r_phase     <= PH_LOAD;
                    r_load_cnt  <= '0;
                    r_drain_cnt <= '0;
                end else begin
                    r_drain_cnt <= r_drain_cnt + CW'(1);
                end
            end
            if (r_pend && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!r_pend && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= w_push;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= w_push;
            end
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end else if (r_pend) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_push;
            end else begin
                r_q1 <= w_push;
            end
        end
    end

    assign w_ram_we = w_load || w_swp_mem.wr_en;
    assign w_ram_wa = (r_phase == PH_LOAD) ? r_load_cnt[AW-1:0] : w_swp_wr_addr;
    assign w_ram_wd = (r_phase == PH_LOAD) ? {w_load_val, w_load_val} : w_swp_wr_data;
    assign w_ram_re = w_drain || w_swp_mem.rd_en;
    assign w_ram_ra = (r_phase == PH_DRAIN) ? r_drain_cnt[AW-1:0] : w_swp_rd_addr;

    edt_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_wa),
        .i_wr_data (w_ram_wd),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_ram_ra),
        .o_rd_data (w_ram_rd)
    );

    edt_sweep #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_sweep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_width   (w_eff_w),
        .i_height  (w_eff_h),
        .o_done    (w_swp_done),
        .o_mem     (w_swp_mem),
        .o_rd_addr (w_swp_rd_addr),
        .o_wr_addr (w_swp_wr_addr),
        .o_wr_data (w_swp_wr_data),
        .i_rd_data (w_ram_rd)
    );

    `EDT_ASSERT_IMP(a_no_input_in_sweep, r_phase == PH_SWEEP, !s_axis_tready)
    `EDT_ASSERT_IMP(a_mem_owner, w_swp_mem.rd_en || w_swp_mem.wr_en, r_phase == PH_SWEEP)
    `EDT_ASSERT_IMP(a_buf_bound, 1'b1, ({1'b0, r_cnt} + {2'b0, r_pend}) <= 3'd2)
    `EDT_ASSERT_NXT(a_drain_pends, w_drain, r_pend)
endmodule
